// ----- rtl/fractal_value_noise_2d_defines.svh -----
// ----------------------------------------------------------------------------
// fractal value noise assertion macros
// shared concurrent check forms for the noise pipeline
// ----------------------------------------------------------------------------
`ifndef FRACTAL_VALUE_NOISE_2D_DEFINES_SVH
`define FRACTAL_VALUE_NOISE_2D_DEFINES_SVH

// same-cycle implication
`define FVN_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fvn check failed");

// next-cycle implication
`define FVN_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fvn check failed");

`endif

// ----- rtl/fvn_pkg.sv -----
// ----------------------------------------------------------------------------
// fvn_pkg
// types, constants and helper functions of the fractal value noise block
// ----------------------------------------------------------------------------
package fvn_pkg;

    localparam int MAX_OCTAVES_DEF    = 8;
    localparam int COS_TABLE_BITS_DEF = 8;

    localparam int COORD_W = 24;
    localparam int SCALE_W = 25;
    localparam int PERS_W  = 17;
    localparam int CNT_W   = 4;
    localparam int POS_W   = COORD_W + SCALE_W;
    localparam int MAG_W   = 56;
    localparam int LAT_W   = 32;
    localparam int VAL_W   = 18;
    localparam int WGT_W   = 17;
    localparam int OUT_W   = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;

    localparam logic [WGT_W-1:0] ONE_Q16 = 17'd65536;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PERSISTENCE  = 2'd0,
        REG_OCTAVE_COUNT = 2'd1,
        REG_COORD_SCALE  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [POS_W-1:0] sx;
        logic [POS_W-1:0] sy;
        logic             nx;
        logic             ny;
    } point_t;

    // (1 - cos(pi*k/2^tb))/2 in q0.16, taylor series in q.30
    function automatic logic [WGT_W-1:0] half_weight(input int k, input int tb);
        logic [63:0] theta;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] q;
        logic signed [63:0] c;
        logic signed [63:0] r;
        theta = (PI_Q30 * 64'(k)) >> tb;
        x2    = (theta * theta) >> 30;
        term  = 64'd1 << 30;
        c     = signed'(term);
        for (int j = 1; j <= 7; j++) begin
            q = (term * x2) >> 30;
            case (j)
                1:       term = q / 64'd2;
                2:       term = q / 64'd12;
                3:       term = q / 64'd30;
                4:       term = q / 64'd56;
                5:       term = q / 64'd90;
                6:       term = q / 64'd132;
                default: term = q / 64'd182;
            endcase
            if ((j % 2) == 1) begin
                c = c - signed'(term);
            end else begin
                c = c + signed'(term);
            end
        end
        if (c > (64'sd1 <<< 30)) begin
            c = 64'sd1 <<< 30;
        end
        if (c < 64'sd0) begin
            c = 64'sd0;
        end
        r = ((((64'sd1 <<< 30) - c) >>> 1) + (64'sd1 <<< 13)) >>> 14;
        return WGT_W'(r);
    endfunction

    function automatic logic [WGT_W-1:0] cos_weight(input int k, input int tb);
        int n;
        n = 1 << tb;
        if (2 * k <= n) begin
            return half_weight(k, tb);
        end
        return ONE_Q16 - half_weight(n - k, tb);
    endfunction

    // signed divide by 65536, truncated toward zero
    function automatic logic signed [23:0] sdiv_q16(input logic signed [39:0] v);
        logic signed [39:0] t;
        t = v + ((v < 40'sd0) ? 40'sd65535 : 40'sd0);
        return 24'(t >>> 16);
    endfunction

    function automatic logic signed [VAL_W-1:0] blend(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b,
        input logic [WGT_W-1:0]        f
    );
        logic signed [VAL_W-1:0] wf;
        logic signed [VAL_W-1:0] wa;
        logic signed [39:0]      acc;
        wf  = signed'({1'b0, f});
        wa  = 18'sd65536 - wf;
        acc = 40'(a * wa) + 40'(b * wf);
        return VAL_W'(sdiv_q16(acc));
    endfunction

endpackage

// ----- rtl/fvn_octave.sv -----
// ----------------------------------------------------------------------------
// fvn_octave
// one noise octave: lattice hash, 3x3 smoothing, cosine blend, weighted add
// ----------------------------------------------------------------------------
`include "fractal_value_noise_2d_defines.svh"

module fvn_octave #(
    parameter int OCTAVE         = 0,
    parameter int COS_TABLE_BITS = fvn_pkg::COS_TABLE_BITS_DEF,
    parameter int TOTAL_W        = 22
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  fvn_pkg::point_t               in_point,
    input  logic signed [TOTAL_W-1:0]     in_total,
    input  logic [fvn_pkg::WGT_W-1:0]     amp,
    input  logic                          active,
    output logic                          out_valid,
    input  logic                          out_ready,
    output fvn_pkg::point_t               out_point,
    output logic signed [TOTAL_W-1:0]     out_total
);

    localparam int ST_SPLIT  = 0;
    localparam int ST_SQ     = 1;
    localparam int ST_POLY   = 2;
    localparam int ST_HASH   = 3;
    localparam int ST_SMOOTH = 4;
    localparam int ST_BLX    = 5;
    localparam int ST_BLY    = 6;
    localparam int ST_MUL    = 7;
    localparam int ST_ACC    = 8;
    localparam int NST       = 9;
    localparam int LUT_N     = 1 << COS_TABLE_BITS;
    localparam int LW        = fvn_pkg::LAT_W;
    localparam int VW        = fvn_pkg::VAL_W;
    localparam int WW        = fvn_pkg::WGT_W;

    logic [NST-1:0] v_reg;
    logic [NST:0]   rdy;

    fvn_pkg::point_t          pt_reg  [NST];
    logic signed [TOTAL_W-1:0] tot_reg [NST];
    logic [WW-1:0]            fx_reg  [NST];
    logic [WW-1:0]            fy_reg  [NST];

    logic [LW-1:0] n0_reg [16];
    logic [LW-1:0] n1_reg [16];
    logic [LW-1:0] sq_reg [16];
    logic [LW-1:0] n2_reg [16];
    logic [LW-1:0] t_reg  [16];
    logic signed [VW-1:0] lv_reg [16];
    logic signed [VW-1:0] sm_reg [4];
    logic signed [VW-1:0] bx_reg [2];
    logic signed [VW-1:0] s_reg;
    logic signed [35:0]   prod_reg;

    logic [WW-1:0] lut [LUT_N];

    logic [fvn_pkg::MAG_W-1:0] mag_x, mag_y;
    logic [LW-1:0] ipx, ipy, ix, iy;
    logic [COS_TABLE_BITS-1:0] kx, ky;
    logic [LW-1:0] gx [4];
    logic [LW-1:0] gy [4];
    logic [LW-1:0] n0 [16];
    logic [LW-1:0] n0_tmp;
    logic signed [VW-1:0] lv [16];
    logic [LW-1:0] h;
    logic signed [21:0] acc;
    logic signed [21:0] adj;
    logic signed [VW-1:0] sm [4];
    logic signed [23:0] term;
    logic signed [TOTAL_W-1:0] tot_acc;

    for (genvar g = 0; g < LUT_N; g++) begin : g_lut
        assign lut[g] = fvn_pkg::cos_weight(g, COS_TABLE_BITS);
    end

    // stall chain
    assign rdy[NST] = out_ready;
    for (genvar s = 0; s < NST; s++) begin : g_rdy
        assign rdy[s] = !v_reg[s] || rdy[s+1];
    end
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NST-1];
    assign out_point = pt_reg[NST-1];
    assign out_total = tot_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int s = 1; s < NST; s++) begin
                if (rdy[s]) begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    // split into lattice index and table index
    always_comb begin
        mag_x = fvn_pkg::MAG_W'(fvn_pkg::MAG_W'(in_point.sx) << OCTAVE);
        mag_y = fvn_pkg::MAG_W'(fvn_pkg::MAG_W'(in_point.sy) << OCTAVE);
        ipx   = mag_x[fvn_pkg::MAG_W-1:24];
        ipy   = mag_y[fvn_pkg::MAG_W-1:24];
        ix    = in_point.nx ? (~ipx + 32'd1) : ipx;
        iy    = in_point.ny ? (~ipy + 32'd1) : ipy;
        kx    = mag_x[23 -: COS_TABLE_BITS];
        ky    = mag_y[23 -: COS_TABLE_BITS];
        for (int j = 0; j < 4; j++) begin
            gx[j] = ix + 32'(j) - 32'd1;
            gy[j] = iy + 32'(j) - 32'd1;
        end
        for (int j = 0; j < 16; j++) begin
            n0_tmp = gx[j % 4] + 32'(gy[j / 4] * 32'd57);
            n0[j]  = n0_tmp ^ (n0_tmp << 13);
        end
    end

    always_comb begin
        for (int j = 0; j < 16; j++) begin
            h     = n2_reg[j] * t_reg[j] + 32'd1376312589;
            lv[j] = 18'sd65536 - signed'({1'b0, h[30:14]});
        end
    end

    // 3x3 smoothing of the four cell corners
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            acc = 22'(lv_reg[(c/2)*4 + (c%2)])     + 22'(lv_reg[(c/2)*4 + (c%2) + 2])
                + 22'(lv_reg[(c/2)*4 + (c%2) + 8]) + 22'(lv_reg[(c/2)*4 + (c%2) + 10]);
            acc = acc + ((22'(lv_reg[(c/2)*4 + (c%2) + 4])
                        + 22'(lv_reg[(c/2)*4 + (c%2) + 6])
                        + 22'(lv_reg[(c/2)*4 + (c%2) + 1])
                        + 22'(lv_reg[(c/2)*4 + (c%2) + 9])) <<< 1);
            acc = acc + (22'(lv_reg[(c/2)*4 + (c%2) + 5]) <<< 2);
            adj = acc + ((acc < 22'sd0) ? 22'sd15 : 22'sd0);
            sm[c] = VW'(adj >>> 4);
        end
    end

    always_comb begin
        term    = fvn_pkg::sdiv_q16(40'(prod_reg));
        tot_acc = tot_reg[ST_MUL] + (active ? TOTAL_W'(term) : TOTAL_W'(0));
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_SPLIT]) begin
            pt_reg[ST_SPLIT]  <= in_point;
            tot_reg[ST_SPLIT] <= in_total;
            fx_reg[ST_SPLIT]  <= lut[kx];
            fy_reg[ST_SPLIT]  <= lut[ky];
            for (int j = 0; j < 16; j++) begin
                n0_reg[j] <= n0[j];
            end
        end
        for (int s = 1; s < NST; s++) begin
            if (rdy[s]) begin
                pt_reg[s] <= pt_reg[s-1];
                fx_reg[s] <= fx_reg[s-1];
                fy_reg[s] <= fy_reg[s-1];
                if (s != ST_ACC) begin
                    tot_reg[s] <= tot_reg[s-1];
                end
            end
        end
        if (rdy[ST_SQ]) begin
            for (int j = 0; j < 16; j++) begin
                n1_reg[j] <= n0_reg[j];
                sq_reg[j] <= 32'(n0_reg[j] * n0_reg[j]);
            end
        end
        if (rdy[ST_POLY]) begin
            for (int j = 0; j < 16; j++) begin
                n2_reg[j] <= n1_reg[j];
                t_reg[j]  <= 32'(sq_reg[j] * 32'd15731) + 32'd789221;
            end
        end
        if (rdy[ST_HASH]) begin
            for (int j = 0; j < 16; j++) begin
                lv_reg[j] <= lv[j];
            end
        end
        if (rdy[ST_SMOOTH]) begin
            for (int c = 0; c < 4; c++) begin
                sm_reg[c] <= sm[c];
            end
        end
        if (rdy[ST_BLX]) begin
            bx_reg[0] <= fvn_pkg::blend(sm_reg[0], sm_reg[1], fx_reg[ST_SMOOTH]);
            bx_reg[1] <= fvn_pkg::blend(sm_reg[2], sm_reg[3], fx_reg[ST_SMOOTH]);
        end
        if (rdy[ST_BLY]) begin
            s_reg <= fvn_pkg::blend(bx_reg[0], bx_reg[1], fy_reg[ST_BLX]);
        end
        if (rdy[ST_MUL]) begin
            prod_reg <= 36'(s_reg * signed'({1'b0, amp}));
        end
        if (rdy[ST_ACC]) begin
            tot_reg[ST_ACC] <= tot_acc;
        end
    end

    for (genvar s = 0; s < NST; s++) begin : g_chk
        `FVN_ASSERT_NEXT(a_stage_hold, aclk, aresetn, v_reg[s] && !rdy[s+1], v_reg[s])
    end

endmodule

// ----- rtl/fractal_value_noise_2d.sv -----
// ----------------------------------------------------------------------------
// fractal_value_noise_2d
// summed octaves of smoothed 2d value noise with cosine interpolation
// ----------------------------------------------------------------------------
// channel   ports                        beat
// input     s_valid / s_ready            coord_x, coord_y (signed 24 bit)
// result    m_valid / m_ready            noise_total (signed q4.16, 21 bit)
// config    cfg_wr_en / cfg_wr_index     cfg_wr_data, no wait, no read-back
//
// one beat per cycle while m_ready does not stall; a beat passes the input register,
// the nine-stage octave units, one per octave, chained, and the output register
// synchronous active-low reset clears valids and loads register defaults
// a stall on m_ready holds only full stages; empty stages keep filling
// ----------------------------------------------------------------------------
`include "fractal_value_noise_2d_defines.svh"

module fractal_value_noise_2d #(
    parameter int MAX_OCTAVES    = fvn_pkg::MAX_OCTAVES_DEF,
    parameter int COS_TABLE_BITS = fvn_pkg::COS_TABLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [fvn_pkg::COORD_W-1:0]  s_coord_x,
    input  logic signed [fvn_pkg::COORD_W-1:0]  s_coord_y,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [fvn_pkg::OUT_W-1:0]    m_noise_total,
    input  logic                                cfg_wr_en,
    input  logic [fvn_pkg::CFG_IDX_W-1:0]       cfg_wr_index,
    input  logic [fvn_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);

    localparam int TOTAL_W = 19 + $clog2(MAX_OCTAVES);
    localparam int WW      = fvn_pkg::WGT_W;

    logic [fvn_pkg::PERS_W-1:0]  persistence_reg;
    logic [fvn_pkg::CNT_W-1:0]   octave_count_reg;
    logic [fvn_pkg::SCALE_W-1:0] coord_scale_reg;

    logic [WW-1:0] amp_reg [MAX_OCTAVES];
    logic [WW-1:0] pers_lim;
    logic [MAX_OCTAVES-1:0] active;

    logic in_v_reg;
    logic in_rdy;
    fvn_pkg::point_t in_pt_reg;
    logic [fvn_pkg::COORD_W-1:0] ax, ay, mx, my;

    logic                      link_v   [MAX_OCTAVES+1];
    logic                      link_rdy [MAX_OCTAVES+1];
    fvn_pkg::point_t           link_pt  [MAX_OCTAVES+1];
    logic signed [TOTAL_W-1:0] link_tot [MAX_OCTAVES+1];

    logic out_v_reg;
    logic out_rdy;
    logic signed [31:0] tot_ext;
    logic signed [fvn_pkg::OUT_W-1:0] noise_reg;
    logic signed [fvn_pkg::OUT_W-1:0] noise_next;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            persistence_reg  <= 17'd6554;
            octave_count_reg <= 4'd5;
            coord_scale_reg  <= 25'd167772;
        end else if (cfg_wr_en) begin
            case (fvn_pkg::cfg_reg_t'(cfg_wr_index))
                fvn_pkg::REG_PERSISTENCE:  persistence_reg  <= cfg_wr_data[fvn_pkg::PERS_W-1:0];
                fvn_pkg::REG_OCTAVE_COUNT: octave_count_reg <= cfg_wr_data[fvn_pkg::CNT_W-1:0];
                fvn_pkg::REG_COORD_SCALE:  coord_scale_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // octave amplitudes, settled long before an item reaches them
    assign pers_lim = (persistence_reg > fvn_pkg::ONE_Q16) ? fvn_pkg::ONE_Q16 : persistence_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g < MAX_OCTAVES; g++) begin
                amp_reg[g] <= fvn_pkg::ONE_Q16;
            end
        end else begin
            amp_reg[0] <= fvn_pkg::ONE_Q16;
            for (int g = 1; g < MAX_OCTAVES; g++) begin
                amp_reg[g] <= WW'((34'(amp_reg[g-1]) * 34'(pers_lim)) >> 16);
            end
        end
    end

    for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_act
        assign active[g] = (32'(octave_count_reg) > g);
    end

    // input stage: magnitude times scale
    assign ax = s_coord_x;
    assign ay = s_coord_y;
    assign mx = ax[fvn_pkg::COORD_W-1] ? (~ax + 24'd1) : ax;
    assign my = ay[fvn_pkg::COORD_W-1] ? (~ay + 24'd1) : ay;

    assign in_rdy  = !in_v_reg || link_rdy[0];
    assign s_ready = in_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (in_rdy) begin
            in_v_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_rdy) begin
            in_pt_reg.sx <= fvn_pkg::POS_W'(mx) * fvn_pkg::POS_W'(coord_scale_reg);
            in_pt_reg.sy <= fvn_pkg::POS_W'(my) * fvn_pkg::POS_W'(coord_scale_reg);
            in_pt_reg.nx <= ax[fvn_pkg::COORD_W-1];
            in_pt_reg.ny <= ay[fvn_pkg::COORD_W-1];
        end
    end

    assign link_v[0]   = in_v_reg;
    assign link_pt[0]  = in_pt_reg;
    assign link_tot[0] = '0;

    for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_oct
        fvn_octave #(
            .OCTAVE         (g),
            .COS_TABLE_BITS (COS_TABLE_BITS),
            .TOTAL_W        (TOTAL_W)
        ) u_octave (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (link_v[g]),
            .in_ready  (link_rdy[g]),
            .in_point  (link_pt[g]),
            .in_total  (link_tot[g]),
            .amp       (amp_reg[g]),
            .active    (active[g]),
            .out_valid (link_v[g+1]),
            .out_ready (link_rdy[g+1]),
            .out_point (link_pt[g+1]),
            .out_total (link_tot[g+1])
        );
    end

    // output register with saturation
    assign out_rdy                = !out_v_reg || m_ready;
    assign link_rdy[MAX_OCTAVES]  = out_rdy;

    always_comb begin
        tot_ext = 32'(link_tot[MAX_OCTAVES]);
        if (tot_ext > 32'sd524288) begin
            noise_next = 21'sd524288;
        end else if (tot_ext < -32'sd524288) begin
            noise_next = -21'sd524288;
        end else begin
            noise_next = fvn_pkg::OUT_W'(tot_ext);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (out_rdy) begin
            out_v_reg <= link_v[MAX_OCTAVES];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_rdy) begin
            noise_reg <= noise_next;
        end
    end

    assign m_valid       = out_v_reg;
    assign m_noise_total = noise_reg;

    for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_chk
        `FVN_ASSERT_IMPL(a_amp_bound, aclk, aresetn, 1'b1, amp_reg[g] <= fvn_pkg::ONE_Q16)
    end
    `FVN_ASSERT_IMPL(a_out_range, aclk, aresetn, m_valid, (m_noise_total >= -21'sd524288) && (m_noise_total <= 21'sd524288))

endmodule

// ----- sim/fractal_value_noise_2d_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractal_value_noise_2d_test
// self-checking bench: directed table of sample points over several register
// settings, then random points under changing settings and handshake idling;
// results match a listed value, else an in-bench fixed-point noise predictor
// ----------------------------------------------------------------------------
module fractal_value_noise_2d_test;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic [16:0]        pers;
        logic [3:0]         octs;
        logic [24:0]        scale;
        logic signed [23:0] x;
        logic signed [23:0] y;
        bit                 known;
        logic signed [20:0] val;
    } row_t;

    logic                               aclk;
    logic                               aresetn;
    logic                               s_valid;
    logic                               s_ready;
    logic signed [fvn_pkg::COORD_W-1:0] s_coord_x;
    logic signed [fvn_pkg::COORD_W-1:0] s_coord_y;
    logic                               m_valid;
    logic                               m_ready;
    logic signed [fvn_pkg::OUT_W-1:0]   m_noise_total;
    logic                               cfg_wr_en;
    logic [fvn_pkg::CFG_IDX_W-1:0]      cfg_wr_index;
    logic [fvn_pkg::CFG_DATA_W-1:0]     cfg_wr_data;

    logic [16:0] cur_pers;
    logic [3:0]  cur_octs;
    logic [24:0] cur_scale;

    logic signed [fvn_pkg::OUT_W-1:0] noise_q[$];
    int          in_beats;
    int          errors;
    int          cycles;
    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          cur_known;
    logic signed [20:0] cur_val;
    row_t        rows[$];

    fractal_value_noise_2d dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_coord_x(s_coord_x), .s_coord_y(s_coord_y),
        .m_valid(m_valid), .m_ready(m_ready), .m_noise_total(m_noise_total),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data)
    );

    always #10 aclk = ~aclk;

    function automatic int lattice_hash(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] n;
        n = x + y * 32'd57;
        n = (n << 13) ^ n;
        n = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
        return 65536 - int'(n >> 14);
    endfunction

    function automatic int smooth_cell(input logic [31:0] x, input logic [31:0] y);
        int c, s, m;
        c = lattice_hash(x - 1, y - 1) + lattice_hash(x + 1, y - 1)
          + lattice_hash(x - 1, y + 1) + lattice_hash(x + 1, y + 1);
        s = lattice_hash(x - 1, y) + lattice_hash(x + 1, y)
          + lattice_hash(x, y - 1) + lattice_hash(x, y + 1);
        m = lattice_hash(x, y);
        return (c + 2 * s + 4 * m) / 16;
    endfunction

    // raised-cosine weight for the lower half of the table, q0.16
    function automatic longint half_ease(input longint k);
        longint unsigned theta, x2, term;
        longint c;
        theta = (64'd3373259426 * k) >> fvn_pkg::COS_TABLE_BITS_DEF;
        x2    = (theta * theta) >> 30;
        term  = 64'd1 << 30;
        c     = longint'(term);
        for (int j = 1; j <= 7; j++) begin
            term = ((term * x2) >> 30) / longint'((2 * j - 1) * (2 * j));
            if (j % 2 == 1) c -= longint'(term);
            else c += longint'(term);
        end
        if (c > (64'sd1 <<< 30)) c = 64'sd1 <<< 30;
        if (c < 0) c = 0;
        return ((((64'sd1 <<< 30) - c) / 2) + 8192) >>> 14;
    endfunction

    function automatic longint ease_weight(input longint k);
        longint n;
        n = 1 << fvn_pkg::COS_TABLE_BITS_DEF;
        if (2 * k <= n) return half_ease(k);
        return 65536 - half_ease(n - k);
    endfunction

    function automatic longint mix_q16(input longint a, input longint b, input longint f);
        return (a * (65536 - f) + b * f) / 65536;
    endfunction

    function automatic logic signed [20:0] noise_at(input logic [23:0] rx,
                                                    input logic [23:0] ry);
        logic nx, ny;
        longint unsigned mx, my, sx, sy, mag, p, amp;
        logic [31:0] ix, iy, t;
        longint kx, ky, fx, fy, v1, v2, v3, v4, smp, total;
        int cnt;
        nx = rx[23];
        ny = ry[23];
        mx = nx ? 64'h1000000 - rx : rx;
        my = ny ? 64'h1000000 - ry : ry;
        sx = mx * cur_scale;
        sy = my * cur_scale;
        p = (cur_pers > 17'd65536) ? 65536 : cur_pers;
        cnt = (cur_octs > 8) ? 8 : cur_octs;
        amp = 65536;
        total = 0;
        for (int i = 0; i < cnt; i++) begin
            mag = sx << i;
            t = mag[55:24];
            ix = nx ? 32'd0 - t : t;
            kx = mag[23:0] >> (24 - fvn_pkg::COS_TABLE_BITS_DEF);
            mag = sy << i;
            t = mag[55:24];
            iy = ny ? 32'd0 - t : t;
            ky = mag[23:0] >> (24 - fvn_pkg::COS_TABLE_BITS_DEF);
            fx = ease_weight(kx);
            fy = ease_weight(ky);
            v1 = smooth_cell(ix, iy);
            v2 = smooth_cell(ix + 1, iy);
            v3 = smooth_cell(ix, iy + 1);
            v4 = smooth_cell(ix + 1, iy + 1);
            smp = mix_q16(mix_q16(v1, v2, fx), mix_q16(v3, v4, fx), fy);
            total += (smp * longint'(amp)) / 65536;
            amp = (amp * p) >> 16;
        end
        if (total > 524288) total = 524288;
        if (total < -524288) total = -524288;
        return 21'(total);
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (aresetn && s_valid && s_ready) begin
            in_beats <= in_beats + 1;
            noise_q.push_back(cur_known ? cur_val : noise_at(s_coord_x, s_coord_y));
        end
        if (aresetn && m_valid && m_ready) begin
            if (noise_q.size() == 0) begin
                $display("%0t: unexpected beat, actual %0d", $time, m_noise_total);
                errors++;
            end else begin
                if (m_noise_total !== noise_q[0]) begin
                    $display("%0t: noise_total expected %0d actual %0d",
                             $time, noise_q[0], m_noise_total);
                    errors++;
                end
                void'(noise_q.pop_front());
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic settle();
        s_valid <= 1'b0;
        while (noise_q.size() != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
    endtask

    task automatic write_config(input logic [16:0] p, input logic [3:0] o,
                                input logic [24:0] s);
        settle();
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= fvn_pkg::REG_PERSISTENCE;
        cfg_wr_data  <= 25'(p);
        @(negedge aclk);
        cfg_wr_index <= fvn_pkg::REG_OCTAVE_COUNT;
        cfg_wr_data  <= 25'(o);
        @(negedge aclk);
        cfg_wr_index <= fvn_pkg::REG_COORD_SCALE;
        cfg_wr_data  <= s;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cur_pers  = p;
        cur_octs  = o;
        cur_scale = s;
        @(negedge aclk);
    endtask

    task automatic send_point(input logic signed [23:0] x, input logic signed [23:0] y,
                              input bit known, input logic signed [20:0] val);
        int target;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_coord_x <= x;
        s_coord_y <= y;
        cur_known = known;
        cur_val   = val;
        target = in_beats + 1;
        do @(negedge aclk); while (in_beats < target);
    endtask

    function automatic logic signed [23:0] pick_coord();
        case ($urandom_range(2))
            0: return 24'($urandom);
            1: return 24'($urandom_range(4000)) - 24'sd2000;
            default: return $urandom_range(1) ? 24'sh7fffff - 24'($urandom_range(3))
                                              : 24'sh800000 + 24'($urandom_range(3));
        endcase
    endfunction

    function automatic row_t mk(input logic [16:0] p, input logic [3:0] o,
                                input logic [24:0] s, input int x, input int y,
                                input bit known = 0, input int val = 0);
        row_t r;
        r.pers = p; r.octs = o; r.scale = s;
        r.x = 24'(x); r.y = 24'(y); r.known = known; r.val = 21'(val);
        return r;
    endfunction

    initial begin
        logic [16:0] p;
        logic [24:0] s;
        aclk = 0;
        aresetn = 0;
        s_valid = 0;
        s_coord_x = 0;
        s_coord_y = 0;
        m_ready = 0;
        cfg_wr_en = 0;
        cfg_wr_index = fvn_pkg::REG_PERSISTENCE;
        cfg_wr_data = 0;
        cur_known = 0;
        cur_val = 0;
        in_beats = 0;
        errors = 0;
        cycles = 0;
        cur_pers = 17'd6554;
        cur_octs = 4'd5;
        cur_scale = 25'd167772;
        tx_idle_pct = 34;
        rx_idle_pct = 67;

        // defaults after reset
        rows.push_back(mk(6554, 5, 167772, 0, 0));
        rows.push_back(mk(6554, 5, 167772, 8388607, 8388607));
        rows.push_back(mk(6554, 5, 167772, -8388608, -8388608));
        rows.push_back(mk(6554, 5, 167772, -8388608, 8388607));
        rows.push_back(mk(6554, 5, 167772, -1, 1));
        rows.push_back(mk(6554, 5, 167772, 123, -456));
        // unit persistence, full octaves, unit scale
        rows.push_back(mk(65536, 8, 16777216, 8388607, -8388608));
        rows.push_back(mk(65536, 8, 16777216, 1, -1));
        rows.push_back(mk(65536, 8, 16777216, 0, 0));
        // persistence above one, octave count above limit, max scale
        rows.push_back(mk(131071, 15, 33554431, 8388607, 8388607));
        rows.push_back(mk(131071, 15, 33554431, -8388608, -1));
        rows.push_back(mk(131071, 15, 33554431, 777, -3));
        // zero scale
        rows.push_back(mk(0, 1, 0, 8388607, -8388608));
        rows.push_back(mk(0, 1, 0, -77, 99));
        // zero octaves sum to nothing
        rows.push_back(mk(65536, 0, 16777216, 5, 7, 1, 0));
        rows.push_back(mk(65536, 0, 16777216, -8388608, 8388607, 1, 0));
        rows.push_back(mk(40000, 3, 1, -8388608, -8388608));
        rows.push_back(mk(40000, 3, 1, 100, 200));
        rows.push_back(mk(32768, 8, 16777215, -5, 3));
        rows.push_back(mk(32768, 8, 16777215, 8388607, 0));

        repeat (4) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        foreach (rows[i]) begin
            if (rows[i].pers != cur_pers || rows[i].octs != cur_octs ||
                rows[i].scale != cur_scale)
                write_config(rows[i].pers, rows[i].octs, rows[i].scale);
            send_point(rows[i].x, rows[i].y, rows[i].known, rows[i].val);
        end

        for (int mode = 0; mode < 3; mode++) begin
            tx_idle_pct = (mode == 0) ? 34 : (mode == 1) ? 67 : 0;
            rx_idle_pct = (mode == 0) ? 67 : (mode == 1) ? 34 : 0;
            for (int chunk = 0; chunk < 4; chunk++) begin
                case ($urandom_range(3))
                    0: p = 0;
                    1: p = 65536;
                    2: p = 17'($urandom_range(131071));
                    default: p = 17'($urandom_range(65535));
                endcase
                case ($urandom_range(4))
                    0: s = 0;
                    1: s = 25'h1ffffff;
                    2: s = 25'($urandom);
                    default: s = 25'($urandom_range(400000, 1));
                endcase
                write_config(p, 4'($urandom_range(15)), s);
                repeat (54) send_point(pick_coord(), pick_coord(), 0, 0);
            end
        end

        s_valid <= 1'b0;
        while (noise_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- fractal_value_noise_2d.f -----
+incdir+rtl
rtl/fvn_pkg.sv
rtl/fvn_octave.sv
rtl/fractal_value_noise_2d.sv
sim/fractal_value_noise_2d_test.sv
